>>> design/cst_pkg.sv
// Shared types, constants and byte-class helpers for the comment-skipping tokenizer.
package cst_pkg;

  localparam int unsigned MAX_CLASS_CHARS = 8;
  localparam int unsigned MAX_RUN = 3;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // configuration register indexes
  localparam logic [1:0] REG_DELIM_CHARS = 2'd0;
  localparam logic [1:0] REG_DELIM_COUNT = 2'd1;
  localparam logic [1:0] REG_SEP_CHARS   = 2'd2;
  localparam logic [1:0] REG_SEP_COUNT   = 2'd3;

  typedef struct packed {
    logic [63:0] delim_chars;
    logic [3:0]  delim_count;
    logic [63:0] sep_chars;
    logic [3:0]  sep_count;
  } class_cfg_t;

  // one result word
  typedef struct packed {
    logic [7:0] ch;
    logic       cv;
    logic       te;
  } res_t;

  // all results caused by one input word, slot 0 first
  typedef struct packed {
    logic [1:0]         cnt;
    res_t [MAX_RUN-1:0] slot;
  } run_t;

  // results of classifying one byte
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
    logic       open;
  } cls_t;

  // front status seen by the top level checks
  typedef struct packed {
    logic mode_normal;
    logic token_open;
  } front_stat_t;

  function automatic logic class_match(input logic [63:0] chars, input logic [3:0] count,
                                       input logic [7:0] b);
    logic [3:0] n;
    logic       m;
    n = (count > 4'(MAX_CLASS_CHARS)) ? 4'(MAX_CLASS_CHARS) : count;
    m = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if ((4'(i) < n) && (chars[8*i +: 8] == b)) m = 1'b1;
    end
    return m;
  endfunction

  function automatic cls_t classify_byte(input logic [7:0] b, input logic open,
                                         input class_cfg_t cfg);
    cls_t c;
    c = '0;
    c.open = open;
    if (class_match(cfg.sep_chars, cfg.sep_count, b)) begin
      if (open) begin
        c.n = 2'd1;
        c.r0 = '{ch: 8'd0, cv: 1'b0, te: 1'b1};
      end
      c.open = 1'b0;
    end else if (class_match(cfg.delim_chars, cfg.delim_count, b)) begin
      if (open) begin
        c.n = 2'd2;
        c.r0 = '{ch: 8'd0, cv: 1'b0, te: 1'b1};
        c.r1 = '{ch: b, cv: 1'b1, te: 1'b1};
      end else begin
        c.n = 2'd1;
        c.r0 = '{ch: b, cv: 1'b1, te: 1'b1};
      end
      c.open = 1'b0;
    end else begin
      c.n = 2'd1;
      c.r0 = '{ch: b, cv: 1'b1, te: 1'b0};
      c.open = 1'b1;
    end
    return c;
  endfunction

  function automatic run_t run_append(input run_t run, input cls_t c);
    run_t r;
    r = run;
    if (c.n >= 2'd1) begin
      r.slot[r.cnt] = c.r0;
      r.cnt = r.cnt + 2'd1;
    end
    if (c.n >= 2'd2) begin
      r.slot[r.cnt] = c.r1;
      r.cnt = r.cnt + 2'd1;
    end
    return r;
  endfunction

endpackage

>>> design/cst_front.sv
// Front end: comment-skipping lexer state machine, turns one input word into a run of results.
module cst_front import cst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  input  class_cfg_t  cfg,
  output run_t        run,
  output front_stat_t stat
);

  typedef enum logic [2:0] {
    M_NORMAL     = 3'd0,
    M_SLASH      = 3'd1,
    M_LINE       = 3'd2,
    M_BLOCK      = 3'd3,
    M_BLOCK_STAR = 3'd4
  } mode_t;

  mode_t mode, mode_next;
  logic  token_open, token_open_next;
  cls_t  cls_slash, cls_after_slash, cls_byte;

  always_comb begin
    cls_slash       = classify_byte(CH_SLASH, token_open, cfg);
    cls_after_slash = classify_byte(in_byte, cls_slash.open, cfg);
    cls_byte        = classify_byte(in_byte, token_open, cfg);
    run             = '0;
    mode_next       = mode;
    token_open_next = token_open;
    if (end_of_input) begin
      if (mode == M_SLASH) begin
        run = run_append(run, cls_slash);
        token_open_next = cls_slash.open;
      end
      if (token_open_next) begin
        run.slot[run.cnt] = '{ch: 8'd0, cv: 1'b0, te: 1'b1};
        run.cnt = run.cnt + 2'd1;
      end
      token_open_next = 1'b0;
      mode_next = M_NORMAL;
    end else begin
      case (mode)
        M_SLASH: begin
          if (in_byte == CH_SLASH) begin
            mode_next = M_LINE;
          end else if (in_byte == CH_STAR) begin
            mode_next = M_BLOCK;
          end else begin
            mode_next = M_NORMAL;
            run = run_append(run, cls_slash);
            run = run_append(run, cls_after_slash);
            token_open_next = cls_after_slash.open;
          end
        end
        M_LINE: begin
          if (in_byte == CH_NL) begin
            mode_next = M_NORMAL;
            run = run_append(run, cls_byte);
            token_open_next = cls_byte.open;
          end
        end
        M_BLOCK: begin
          if (in_byte == CH_STAR) mode_next = M_BLOCK_STAR;
        end
        M_BLOCK_STAR: begin
          if (in_byte == CH_SLASH) mode_next = M_NORMAL;
          else if (in_byte != CH_STAR) mode_next = M_BLOCK;
        end
        default: begin
          if (in_byte == CH_SLASH) begin
            mode_next = M_SLASH;
          end else begin
            mode_next = M_NORMAL;
            run = run_append(run, cls_byte);
            token_open_next = cls_byte.open;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_NORMAL;
      token_open <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      token_open <= token_open_next;
    end
  end

  assign stat.mode_normal = (mode == M_NORMAL);
  assign stat.token_open  = token_open;

endmodule

>>> design/cst_queue.sv
// Small run queue between the lexer front end and the result serializer.
module cst_queue import cst_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  run_t wr_data,
  input  logic rd_en,
  output run_t rd_data,
  output logic full,
  output logic nonempty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  run_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (rd_en) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (wr_en && !rd_en) count <= count + CW'(1);
      else if (rd_en && !wr_en) count <= count - CW'(1);
    end
  end

  assign rd_data  = mem[rd_ptr];
  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);

endmodule

>>> design/cst_back.sv
// Back end: holds one run and hands its results out one word per pop.
module cst_back import cst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  run_t       head,
  input  logic       head_valid,
  output logic       head_take,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] token_char,
  output logic       char_valid,
  output logic       token_end,
  output logic       last_of_run
);

  run_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       last;
  res_t       res;

  assign last      = (idx == cur.cnt - 2'd1);
  assign head_take = head_valid && (!cur_valid || (pop && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (head_take) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (pop && cur_valid) begin
      if (last) cur_valid <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_take) cur <= head;
  end

  assign res         = cur.slot[idx];
  assign empty       = !cur_valid;
  assign token_char  = res.ch;
  assign char_valid  = res.cv;
  assign token_end   = res.te;
  assign last_of_run = last;

endmodule

>>> design/comment_skipping_tokenizer_top.sv
// Top level of the comment-skipping tokenizer: config registers, front, run queue, back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | push / full          | in_byte[7:0], end_of_input
//  result   | empty / pop          | token_char[7:0], char_valid, token_end, last_of_run
//  config   | cfg_valid / cfg_ready| cfg_index[1:0], cfg_data[63:0]
//
// Cycles: one input word per cycle while full is low; the lexer classifies it and
//   queues its run (zero to three result words) in the same cycle. Result words leave
//   one per cycle while pop is high; the back-end serializer sets the sustained pace.
// Path: a result word is registered in the run queue, then in the back-end run register.
// Reset: synchronous; lexer returns to normal mode, no token open, queues empty,
//   all config registers zero.
// Stalls: full rises when the run queue is full; words that make no result never
//   take a queue slot. cfg_ready is always high.
module comment_skipping_tokenizer_top import cst_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  token_char,
  output logic        char_valid,
  output logic        token_end,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  class_cfg_t  cfg;
  run_t        run, head;
  front_stat_t stat;
  logic        accept, q_push, q_full, q_nonempty, head_take;

  assign cfg_ready = 1'b1;

  // config registers; user must write only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DELIM_CHARS: cfg.delim_chars <= cfg_data;
        REG_DELIM_COUNT: cfg.delim_count <= cfg_data[3:0];
        REG_SEP_CHARS:   cfg.sep_chars   <= cfg_data;
        REG_SEP_COUNT:   cfg.sep_count   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign full   = q_full;
  assign accept = push && !full;
  // runs with no words are dropped here
  assign q_push = accept && (run.cnt != 2'd0);

  cst_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .cfg          (cfg),
    .run          (run),
    .stat         (stat)
  );

  cst_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (run),
    .rd_en    (head_take),
    .rd_data  (head),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  cst_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (q_nonempty),
    .head_take   (head_take),
    .pop         (pop),
    .empty       (empty),
    .token_char  (token_char),
    .char_valid  (char_valid),
    .token_end   (token_end),
    .last_of_run (last_of_run)
  );

  // end of input always leaves the lexer in normal mode with no open token
  a_eoi_flush: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_input) |=> (stat.mode_normal && !stat.token_open))
    else $error("lexer not flushed after end of input");

  // a run word that is not the last one is followed by more words of the same run
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_of_run) |=> !empty)
    else $error("run cut short");

  // a bare end mark always ends a token
  a_bare_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && !char_valid) |-> (token_end && token_char == 8'd0))
    else $error("bare end mark malformed");

  // queue never overwritten
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("run queue overflow");

endmodule

>>> dv/testbench.sv
// Testbench for comment_skipping_tokenizer_top: random text stream, lexer predictor, word checks.
module testbench;
  import cst_pkg::*;

  localparam int QUIET_LIMIT = 1000;  // cycles with no accepted word before giving up
  localparam int DRAIN_PAUSE = 4;     // pause after the drain; leave margin

  typedef enum logic [2:0] {
    LX_NORMAL,
    LX_SLASH,
    LX_LINE,
    LX_BLOCK,
    LX_BLOCK_STAR
  } lex_mode_e;

  // one input word
  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
  } text_word_t;

  // one predicted result word
  typedef struct packed {
    logic [7:0] ch;
    logic       cv;
    logic       te;
    logic       last;
  } tok_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = 8'h00;
  logic        end_of_input = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  token_char;
  logic        char_valid;
  logic        token_end;
  logic        last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [63:0] cfg_data = 64'd0;

  comment_skipping_tokenizer_top DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .empty        (empty),
    .pop          (pop),
    .token_char   (token_char),
    .char_valid   (char_valid),
    .token_end    (token_end),
    .last_of_run  (last_of_run),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Lexer state mirror and expected token words
  // ---------------------------------------------------------------------------
  class_cfg_t  cfg_m = '0;
  lex_mode_e   mode_m = LX_NORMAL;
  logic        tok_open_m = 1'b0;
  tok_word_t   tok_q[$];
  text_word_t  text_q[$];

  int miss_cnt = 0;
  int res_cnt = 0;
  int quiet_cycles = 0;

  // count field is clipped to eight entries
  function automatic logic in_class(input logic [63:0] chars, input logic [3:0] count,
                                    input logic [7:0] b);
    int n;
    n = (count > 4'd8) ? 8 : int'(count);
    for (int i = 0; i < n; i++) begin
      if (chars[8*i +: 8] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic put_tok(input logic [7:0] ch, input logic cv, input logic te);
    tok_word_t w;
    w.ch = cv ? ch : 8'h00;
    w.cv = cv;
    w.te = te;
    w.last = 1'b0;
    tok_q.insert(tok_q.size(), w);
  endtask

  // separator closes a token; delimiter closes it and stands alone
  task automatic sort_byte(input logic [7:0] b);
    if (in_class(cfg_m.sep_chars, cfg_m.sep_count, b)) begin
      if (tok_open_m) put_tok(8'h00, 1'b0, 1'b1);
      tok_open_m = 1'b0;
    end else if (in_class(cfg_m.delim_chars, cfg_m.delim_count, b)) begin
      if (tok_open_m) put_tok(8'h00, 1'b0, 1'b1);
      tok_open_m = 1'b0;
      put_tok(b, 1'b1, 1'b1);
    end else begin
      put_tok(b, 1'b1, 1'b0);
      tok_open_m = 1'b1;
    end
  endtask

  task automatic lex_word(input logic [7:0] b, input logic eoi);
    int n0;
    n0 = tok_q.size();
    if (eoi) begin
      // flush: held slash is classified, open token gets a bare end mark
      if (mode_m == LX_SLASH) sort_byte(CH_SLASH);
      if (tok_open_m) put_tok(8'h00, 1'b0, 1'b1);
      tok_open_m = 1'b0;
      mode_m = LX_NORMAL;
    end else begin
      case (mode_m)
        LX_SLASH: begin
          if (b == CH_SLASH) mode_m = LX_LINE;
          else if (b == CH_STAR) mode_m = LX_BLOCK;
          else begin
            mode_m = LX_NORMAL;
            sort_byte(CH_SLASH);
            sort_byte(b);
          end
        end
        LX_LINE: begin
          // the newline ending a line comment is lexed as usual
          if (b == CH_NL) begin
            mode_m = LX_NORMAL;
            sort_byte(b);
          end
        end
        LX_BLOCK: begin
          if (b == CH_STAR) mode_m = LX_BLOCK_STAR;
        end
        LX_BLOCK_STAR: begin
          if (b == CH_SLASH) mode_m = LX_NORMAL;
          else if (b != CH_STAR) mode_m = LX_BLOCK;
        end
        default: begin
          mode_m = LX_NORMAL;
          if (b == CH_SLASH) mode_m = LX_SLASH;
          else sort_byte(b);
        end
      endcase
    end
    if (tok_q.size() > n0) tok_q[tok_q.size()-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // byte mix biased toward the characters the lexer cares about
  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 9))
      0, 1: return 8'($urandom);
      2: return CH_SLASH;
      3: return CH_STAR;
      4: return CH_NL;
      5: return 8'h20;
      6: return 8'h3B;
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  function automatic logic [63:0] rand_chars();
    logic [63:0] c;
    for (int i = 0; i < 8; i++) c[8*i +: 8] = text_byte();
    return c;
  endfunction

  function automatic logic [7:0] pick_class(input logic [63:0] chars, input logic [3:0] count);
    int n;
    n = (count > 4'd8) ? 8 : int'(count);
    if (n == 0) return text_byte();
    return chars[8*$urandom_range(0, n-1) +: 8];
  endfunction

  task automatic queue_word(input logic [7:0] b, input logic eoi);
    text_word_t w;
    w.b = b;
    w.eoi = eoi;
    text_q.insert(text_q.size(), w);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_word(s[i], 1'b0);
  endtask

  // mostly well formed C-like pieces, some noise and broken comments
  task automatic queue_snippet();
    int k;
    int len;
    k = $urandom_range(0, 19);
    if (k < 6) begin
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++)
        queue_word(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(8'h61, 8'h7A)),
                   1'b0);
    end else if (k < 8) begin
      queue_word(pick_class(cfg_m.sep_chars, cfg_m.sep_count), 1'b0);
    end else if (k < 10) begin
      queue_word(pick_class(cfg_m.delim_chars, cfg_m.delim_count), 1'b0);
    end else if (k < 12) begin
      queue_text("//");
      len = $urandom_range(0, 4);
      for (int i = 0; i < len; i++) queue_word(text_byte(), 1'b0);
      if ($urandom_range(0, 4) != 0) queue_word(CH_NL, 1'b0);
    end else if (k < 14) begin
      queue_text("/*");
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) queue_word(text_byte(), 1'b0);
      if ($urandom_range(0, 4) != 0) queue_text("*/");
    end else if (k < 16) begin
      queue_word(CH_SLASH, 1'b0);
      queue_word(text_byte(), 1'b0);
    end else if (k < 19) begin
      queue_word(text_byte(), 1'b0);
    end else begin
      queue_word(8'($urandom), 1'b1);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_DELIM_CHARS: cfg_m.delim_chars = data;
      REG_DELIM_COUNT: cfg_m.delim_count = data[3:0];
      REG_SEP_CHARS:   cfg_m.sep_chars = data;
      REG_SEP_COUNT:   cfg_m.sep_count = data[3:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic report_miss(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("MISMATCH result word %0d: %s got %0h want %0h", res_cnt, what, got, want);
    miss_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of words with random gaps; predicts on each accepted word
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    text_word_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) lex_word(in_byte, end_of_input);
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (text_q.size() != 0) begin
          nxt = text_q.pop_front();
          push         <= 1'b1;
          in_byte      <= nxt.b;
          end_of_input <= nxt.eoi;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: pops on its own stall pattern, checks each word against the oldest
  // ---------------------------------------------------------------------------
  logic [7:0] pop_pat = 8'h00;
  int         pop_bits_left = 0;

  always @(posedge clk) begin
    tok_word_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (tok_q.size() == 0) begin
          report_miss("word with none pending, token_char", token_char, 8'h00);
        end else begin
          want = tok_q.pop_front();
          if (token_char !== want.ch) report_miss("token_char", token_char, want.ch);
          if (char_valid !== want.cv) report_miss("char_valid", 8'(char_valid), 8'(want.cv));
          if (token_end !== want.te) report_miss("token_end", 8'(token_end), 8'(want.te));
          if (last_of_run !== want.last)
            report_miss("last_of_run", 8'(last_of_run), 8'(want.last));
        end
        res_cnt++;
      end
      // a quarter of the patterns never stall
      if (pop_bits_left == 0) begin
        pop_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        pop_bits_left = 8;
      end
      pop <= pop_pat[0];
      pop_pat = pop_pat >> 1;
      pop_bits_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles in which no word moves on any channel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Phases: set the byte classes while idle, then stream text through
  // ---------------------------------------------------------------------------
  initial begin
    int target;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          // C-like: whitespace separates, punctuation and '/' delimit
          write_reg(REG_SEP_CHARS, 64'h0000_0000_0D0A_0920);
          write_reg(REG_SEP_COUNT, 64'd4);
          write_reg(REG_DELIM_CHARS, 64'h2F3D_2C7D_7B29_283B);
          write_reg(REG_DELIM_COUNT, 64'd8);
        end
        1: begin
          // no classes at all: every byte is ordinary
          write_reg(REG_DELIM_CHARS, rand_chars());
          write_reg(REG_DELIM_COUNT, 64'd0);
          write_reg(REG_SEP_CHARS, rand_chars());
          write_reg(REG_SEP_COUNT, 64'd0);
        end
        2: begin
          // '*', '/' and newline as separators, overlapping random delimiters
          write_reg(REG_SEP_CHARS, 64'hFF00_6109_200A_2F2A);
          write_reg(REG_SEP_COUNT, 64'd8);
          write_reg(REG_DELIM_CHARS, rand_chars());
          write_reg(REG_DELIM_COUNT, 64'd8);
        end
        3: begin
          // counts above eight clip; upper data bits of a count write are dropped
          write_reg(REG_SEP_CHARS, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(REG_SEP_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(REG_DELIM_CHARS, 64'h0000_0000_0000_0000);
          write_reg(REG_DELIM_COUNT, 64'hA5A5_0000_0000_000C);
        end
        default: begin
          write_reg(REG_SEP_CHARS, rand_chars());
          write_reg(REG_SEP_COUNT, 64'($urandom_range(0, 15)));
          write_reg(REG_DELIM_CHARS, rand_chars());
          write_reg(REG_DELIM_COUNT, 64'($urandom_range(0, 15)));
        end
      endcase

      if (ph == 0) begin
        queue_text("a b;");        // separator and delimiter end tokens
        queue_text("/x");          // held slash then ordinary byte
        queue_text("c//z\n");      // line comment; its newline is lexed
        queue_text("/*/*/");       // slash-star-slash does not close
        queue_word(8'h00, 1'b0);
        queue_word(8'hFF, 1'b0);
        queue_word(8'hFF, 1'b1);   // end of input closes open token
        queue_word(CH_SLASH, 1'b0);
        queue_word(8'h00, 1'b1);   // end of input releases held slash
        queue_text("/*");
        queue_word(8'h5A, 1'b1);   // unterminated block comment
      end

      target = text_q.size() + ((ph == 0) ? 60 : 52);
      while (text_q.size() < target) queue_snippet();

      // idle before touching the registers again
      while (text_q.size() != 0 || push || tok_q.size() != 0) @(posedge clk);
      repeat (DRAIN_PAUSE) @(posedge clk);
    end

    if (miss_cnt == 0 && tok_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
